### rtl/qmps_pkg.sv
package qmps_pkg;
    localparam int MaxSpsDef = 16;
    localparam int TapsDef = 16;
    localparam int TapDepth = 256;

    typedef enum logic [2:0] {
        REG_BPS, REG_SPS, REG_COS, REG_SIN, REG_TSEL, REG_TVAL
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE, ST_MAP, ST_ACC, ST_OUT
    } t_state;
endpackage

### rtl/qam_mapper_polyphase_shaper.sv
// Each symbol is mapped, then each branch is computed with one tap/history read per cycle
// into one complex multiply-accumulate unit, which is drained before the branch sample is output.
// A new request is accepted only once every branch of the previous symbol has been output;
// output stalls delay this. Synchronous active-low reset clears control, configuration
// and the history (through per-entry valid bits); the tap store is undefined until written.
module qam_mapper_polyphase_shaper
    import qmps_pkg::*;
#(
    parameter int MAX_SPS = MaxSpsDef,
    parameter int TAPS_PER_BRANCH = TapsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // symbol_index[9:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // sample_i[23:0], sample_q[47:24]
    output logic [3:0]  m_axis_tuser,   // branch[3:0]
    output logic        m_axis_tlast    // last_of_symbol
);
    localparam int HW = (TAPS_PER_BRANCH > 1) ? $clog2(TAPS_PER_BRANCH) : 1;
    localparam logic [HW:0] NTAPS = TAPS_PER_BRANCH[HW:0];

    logic [3:0]  r_bps;
    logic [4:0]  r_sps;
    logic signed [15:0] r_cos, r_sin;
    logic [7:0]  r_tsel;

    logic signed [15:0] tap_mem [TapDepth];
    logic [35:0] hist_mem [TAPS_PER_BRANCH];
    logic [TAPS_PER_BRANCH-1:0] r_hvalid;
    logic [HW-1:0] r_head;

    t_state r_st, n_st;
    logic [9:0]  r_idx;
    logic [4:0]  r_p;
    logic [HW:0] r_j;
    logic        r_rd_v;
    logic        r_rd_ok;
    logic signed [15:0] r_tap;
    logic [35:0] r_hdat;
    logic        r_hv;
    logic signed [33:0] r_pre, r_pim;
    logic        r_pv;
    logic signed [41:0] r_are, r_aim;
    logic [47:0] r_odata;
    logic [3:0]  r_obr;
    logic        r_olast, r_ovld;

    logic [4:0] sps_e;
    logic [3:0] k_e;
    always_comb begin
        k_e = (r_bps > 4'd10) ? 4'd10 : r_bps;
        if (r_sps == 5'd0) sps_e = 5'd1;
        else if (32'(r_sps) > MAX_SPS) sps_e = 5'(MAX_SPS);
        else sps_e = r_sps;
    end

    // constellation mapping
    logic [3:0] cb, rb;
    logic [9:0] mi;
    logic signed [11:0] lre, lim;
    logic signed [28:0] sre_w, sim_w;
    logic signed [17:0] sre, sim;
    always_comb begin
        cb = k_e >> 1;
        rb = k_e - cb;
        mi = r_idx & ((10'd1 << k_e) - 10'd1);
        lre = 12'(signed'({1'b0, mi >> cb}) * 2) - 12'(signed'({1'b0, 11'd1 << rb})) + 12'sd1;
        lim = 12'(signed'({1'b0, mi & ((10'd1 << cb) - 10'd1)}) * 2)
            - 12'(signed'({1'b0, 11'd1 << cb})) + 12'sd1;
        sre_w = 29'(lre * r_cos) - 29'(lim * r_sin);
        sim_w = 29'(lre * r_sin) + 29'(lim * r_cos);
        sre = (sre_w > 29'sd131071) ? 18'sd131071 :
              (sre_w < -29'sd131072) ? -18'sd131072 : sre_w[17:0];
        sim = (sim_w > 29'sd131071) ? 18'sd131071 :
              (sim_w < -29'sd131072) ? -18'sd131072 : sim_w[17:0];
    end

    // tap address j*sps+p, history address head+j wrapped to the history depth
    logic [11:0] taddr;
    logic [HW-1:0] jj;
    logic [HW:0] hsum;
    logic [HW-1:0] haddr;
    logic [HW-1:0] head_dec;
    always_comb begin
        jj = r_j[HW-1:0];
        taddr = 12'(r_j) * 12'(sps_e) + 12'(r_p);
        hsum = {1'b0, r_head} + {1'b0, jj};
        haddr = (hsum >= NTAPS) ? HW'(hsum - NTAPS) : hsum[HW-1:0];
        head_dec = (r_head == '0) ? HW'(TAPS_PER_BRANCH - 1) : HW'(r_head - HW'(1));
    end

    logic out_free;
    assign out_free = !r_ovld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (i_cfg_we && i_cfg_idx == REG_TVAL) tap_mem[r_tsel] <= i_cfg_data;
        r_tap <= tap_mem[taddr[7:0]];
        r_hdat <= hist_mem[haddr];
        r_hv <= r_hvalid[haddr];
        if (r_st == ST_MAP) hist_mem[r_head] <= {sim, sre};
    end

    assign s_axis_tready = (r_st == ST_IDLE);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (s_axis_tvalid) n_st = ST_MAP;
            ST_MAP:  n_st = ST_ACC;
            ST_ACC:  if (32'(r_j) == TAPS_PER_BRANCH && !r_rd_v && !r_pv)
                         n_st = ST_OUT;
            ST_OUT:  if (out_free) n_st = (r_p + 5'd1 == sps_e) ? ST_IDLE : ST_ACC;
            default: n_st = ST_IDLE;
        endcase
    end

    logic signed [41:0] rnd_re, rnd_im;
    logic signed [23:0] o_re, o_im;
    always_comb begin
        rnd_re = (r_are + 42'sd8192) >>> 14;
        rnd_im = (r_aim + 42'sd8192) >>> 14;
        o_re = (rnd_re > 42'sd8388607) ? 24'sh7FFFFF :
               (rnd_re < -42'sd8388608) ? 24'sh800000 : rnd_re[23:0];
        o_im = (rnd_im > 42'sd8388607) ? 24'sh7FFFFF :
               (rnd_im < -42'sd8388608) ? 24'sh800000 : rnd_im[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_bps <= 4'd2; r_sps <= 5'd4; r_cos <= 16'sd11585; r_sin <= 16'sd0;
            r_tsel <= 8'd0;
            r_hvalid <= '0; r_head <= '0;
            r_rd_v <= 1'b0; r_pv <= 1'b0; r_ovld <= 1'b0;
            r_j <= '0; r_p <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_BPS:  r_bps <= i_cfg_data[3:0];
                    REG_SPS:  r_sps <= i_cfg_data[4:0];
                    REG_COS:  r_cos <= i_cfg_data;
                    REG_SIN:  r_sin <= i_cfg_data;
                    REG_TSEL: r_tsel <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_st == ST_OUT && out_free) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;
            r_rd_v <= (r_st == ST_ACC) && (32'(r_j) < TAPS_PER_BRANCH);
            r_pv <= r_rd_v;
            unique case (r_st)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_idx <= s_axis_tdata[9:0];
                    r_head <= head_dec;
                end
                ST_MAP: begin
                    r_hvalid[r_head] <= 1'b1;
                    r_p <= '0; r_j <= '0;
                end
                ST_ACC: if (32'(r_j) < TAPS_PER_BRANCH) begin
                    r_rd_ok <= (taddr < 12'(TapDepth));
                    r_j <= r_j + 1'b1;
                end
                ST_OUT: if (out_free) begin
                    r_odata <= {o_im, o_re};
                    r_obr <= r_p[3:0];
                    r_olast <= (r_p + 5'd1 == sps_e);
                    r_p <= r_p + 5'd1;
                    r_j <= '0;
                end
                default: ;
            endcase
            if (r_st == ST_MAP || (r_st == ST_OUT && out_free)) begin
                r_are <= '0; r_aim <= '0;
            end else if (r_pv) begin
                r_are <= r_are + 42'(r_pre);
                r_aim <= r_aim + 42'(r_pim);
            end
        end
    end

    // pipeline: address -> memory read -> product -> accumulate
    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            if (r_rd_ok && r_hv) begin
                r_pre <= signed'(r_hdat[17:0]) * r_tap;
                r_pim <= signed'(r_hdat[35:18]) * r_tap;
            end else begin
                r_pre <= '0; r_pim <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_obr;
    assign m_axis_tlast = r_olast;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_ACC |-> !s_axis_tready) else $error("accept while busy");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> 5'(m_axis_tuser) + 5'd1 == sps_e)
        else $error("last on wrong branch");
endmodule

### test/tb_qam_mapper_polyphase_shaper.sv
`timescale 1ns / 1ps

module tb_qam_mapper_polyphase_shaper;
    import qmps_pkg::*;

    localparam int TAPS = 16;
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_CYCLES = 900;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        logic signed [23:0] s_i;
        logic signed [23:0] s_q;
        logic [3:0]         branch;
        logic               last;
    } t_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // symbol_index[9:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // sample_i[23:0], sample_q[47:24]
    logic [3:0]  m_axis_tuser;         // branch[3:0]
    logic        m_axis_tlast;         // last_of_symbol

    qam_mapper_polyphase_shaper dut (.*);

    // shadow of the block's configuration and state
    logic [3:0]         bps;
    logic [4:0]         sps;
    logic signed [15:0] cos_f;
    logic signed [15:0] sin_f;
    logic [7:0]         tap_sel;
    logic signed [15:0] taps [256];
    logic signed [17:0] hist_re [TAPS];
    logic signed [17:0] hist_im [TAPS];

    t_sample samples_due[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_req = 0;
    int      hold_seen = 0;
    int      hold_cnt = 0;
    int      quiet_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // map one symbol, shift it in and queue the samples of every branch
    function automatic void shape_symbol(logic [9:0] sym);
        int k, n, colbits, rowbits, idx, r, c, ti;
        longint lre, lim, acc_re, acc_im;
        t_sample s;
        k = (bps > 10) ? 10 : bps;
        n = (sps == 0) ? 1 : (sps > 16) ? 16 : sps;
        colbits = k / 2;
        rowbits = k - colbits;
        idx = sym & ((1 << k) - 1);
        r = idx >> colbits;
        c = idx & ((1 << colbits) - 1);
        lre = 2 * r - (1 << rowbits) + 1;
        lim = 2 * c - (1 << colbits) + 1;
        for (int j = TAPS - 1; j > 0; j--) begin
            hist_re[j] = hist_re[j-1];
            hist_im[j] = hist_im[j-1];
        end
        hist_re[0] = 18'(clip(lre * cos_f - lim * sin_f, -131072, 131071));
        hist_im[0] = 18'(clip(lre * sin_f + lim * cos_f, -131072, 131071));
        for (int p = 0; p < n; p++) begin
            acc_re = 0;
            acc_im = 0;
            for (int j = 0; j < TAPS; j++) begin
                ti = j * n + p;
                if (ti < 256) begin
                    acc_re += longint'(hist_re[j]) * taps[ti];
                    acc_im += longint'(hist_im[j]) * taps[ti];
                end
            end
            s.s_i = 24'(clip((acc_re + 8192) >>> 14, -8388608, 8388607));
            s.s_q = 24'(clip((acc_im + 8192) >>> 14, -8388608, 8388607));
            s.branch = p[3:0];
            s.last = (p + 1 == n);
            samples_due = {samples_due, s};
        end
    endfunction

    task automatic cfg_write(t_reg r, logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (r)
            REG_BPS:  bps = v[3:0];
            REG_SPS:  sps = v[4:0];
            REG_COS:  cos_f = v;
            REG_SIN:  sin_f = v;
            REG_TSEL: tap_sel = v[7:0];
            REG_TVAL: taps[tap_sel] = v;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // fill the whole tap store; max_mag bounds the coefficient size, all_max sets every tap to 0x7fff
    task automatic load_taps(int max_mag, bit all_max);
        for (int t = 0; t < 256; t++) begin
            cfg_write(REG_TSEL, 16'(t));
            cfg_write(REG_TVAL, all_max ? 16'h7fff : 16'($urandom_range(2 * max_mag) - max_mag));
        end
    endtask

    task automatic send_symbol(logic [9:0] sym);
        if (send_idle_pct > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, sym};
        do @(posedge i_clk); while (!s_axis_tready);
        shape_symbol(sym);
    endtask

    // drain the pipeline before touching the configuration
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_idle(t_idle m);
        send_idle_pct = (m == IDLE_SEND) ? 75 : (m == IDLE_BOTH) ? 24 : 0;
        recv_stall_pct = (m == IDLE_RECV) ? 75 : (m == IDLE_BOTH) ? 24 : 0;
    endtask

    task automatic test_reset_defaults();
        load_taps(4000, 1'b0);
        for (int s = 0; s < 4; s++) send_symbol(10'(s));
        send_symbol(10'h3ff);
        wait_drained();
    endtask

    task automatic test_constellation_edges();
        logic [3:0] bps_list [5] = '{4'd0, 4'd1, 4'd10, 4'd15, 4'd7};
        foreach (bps_list[n]) begin
            cfg_write(REG_BPS, 16'(bps_list[n]));
            send_symbol(10'h000);
            send_symbol(10'h3ff);
            send_symbol(10'h2aa);
            wait_drained();
        end
    endtask

    task automatic test_rate_edges();
        logic [4:0] sps_list [4] = '{5'd0, 5'd1, 5'd16, 5'd31};
        cfg_write(REG_BPS, 16'd10);
        foreach (sps_list[n]) begin
            cfg_write(REG_SPS, 16'(sps_list[n]));
            send_symbol(10'h155);
            send_symbol(10'h3ff);
            wait_drained();
        end
    endtask

    task automatic test_saturation();
        cfg_write(REG_COS, 16'h8000);
        cfg_write(REG_SIN, 16'h7fff);
        cfg_write(REG_SPS, 16'd2);
        load_taps(0, 1'b1);
        for (int s = 0; s < 4; s++) send_symbol(s[0] ? 10'h000 : 10'h3ff);
        wait_drained();
        cfg_write(REG_SIN, 16'h8000);
        cfg_write(REG_COS, 16'h7fff);
        load_taps(32768, 1'b0);
        send_symbol(10'h3ff);
        send_symbol(10'h000);
        wait_drained();
    endtask

    task automatic test_random(t_idle m, int n_items);
        set_idle(m);
        cfg_write(REG_BPS, 16'($urandom_range(15)));
        cfg_write(REG_SPS,
                  16'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 4)));
        cfg_write(REG_COS, 16'($urandom));
        cfg_write(REG_SIN, 16'($urandom));
        load_taps($urandom_range(1, 32768), 1'b0);
        for (int n = 0; n < n_items; n++) send_symbol(10'($urandom_range(1023)));
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_idle(IDLE_NONE);
        cfg_write(REG_SPS, 16'd4);
        hold_req++;
        for (int n = 0; n < 12; n++) send_symbol(10'($urandom_range(1023)));
        // sender pause until the block has emptied
        wait_drained();
        for (int n = 0; n < 6; n++) send_symbol(10'($urandom_range(1023)));
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_sample e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (samples_due.size() == 0) begin
                $display("%0t: unexpected sample expected none actual %h/%h/%h",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                e = samples_due.pop_front();
                if (m_axis_tdata[23:0] !== e.s_i) begin
                    $display("%0t: sample_i expected %0d actual %0d",
                             $time, e.s_i, $signed(m_axis_tdata[23:0]));
                    errors++;
                end
                if (m_axis_tdata[47:24] !== e.s_q) begin
                    $display("%0t: sample_q expected %0d actual %0d",
                             $time, e.s_q, $signed(m_axis_tdata[47:24]));
                    errors++;
                end
                if (m_axis_tuser !== e.branch) begin
                    $display("%0t: branch expected %0d actual %0d", $time, e.branch, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        // count cycles with work pending but no request moving
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (!s_axis_tvalid && samples_due.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bps = 2;
        sps = 4;
        cos_f = 11585;
        sin_f = 0;
        tap_sel = 0;
        foreach (hist_re[j]) begin
            hist_re[j] = 0;
            hist_im[j] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_constellation_edges();
        test_rate_edges();
        test_saturation();
        test_random(IDLE_NONE, 30);
        test_random(IDLE_SEND, 30);
        test_random(IDLE_RECV, 30);
        test_random(IDLE_BOTH, 30);
        test_backpressure();
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/qmps_pkg.sv
rtl/qam_mapper_polyphase_shaper.sv
test/tb_qam_mapper_polyphase_shaper.sv
